>>> hw/rtl/acpa_pkg.sv
// ----------------------------------------------------------------------------
// acpa_pkg
// Shared types and constants for the affine character plot address unit:
// request structs, register indexes, reset values and dimension limits.
// ----------------------------------------------------------------------------
package acpa_pkg;

    // coefficient and dimension formats
    localparam int COEF_W = 32;
    localparam int FRAC_BITS = 16;
    localparam int COORD_W = 16;
    localparam int DIM_W = 9;
    localparam int ADDR_W = 16;
    localparam int GLYPH_W = 8;
    localparam int CFG_IDX_W = 3;

    // largest usable screen dimension, larger register values saturate
    localparam logic [DIM_W-1:0] MAX_DIM = 9'd256;

    // glyph treated as transparent
    localparam logic [GLYPH_W-1:0] SPACE_CODE = 8'h20;

    // register reset values
    localparam logic [COEF_W-1:0] COEF_ONE = 32'h0001_0000;
    localparam logic [COEF_W-1:0] COEF_ZERO = 32'h0000_0000;
    localparam logic [DIM_W-1:0] WIDTH_RESET = 9'd80;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 9'd25;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_XX       = 3'd0,
        CFG_COEF_XY       = 3'd1,
        CFG_OFFSET_X      = 3'd2,
        CFG_COEF_YX       = 3'd3,
        CFG_COEF_YY       = 3'd4,
        CFG_OFFSET_Y      = 3'd5,
        CFG_SCREEN_WIDTH  = 3'd6,
        CFG_SCREEN_HEIGHT = 3'd7
    } t_cfg_idx;

    // input request: one source point
    typedef struct packed {
        logic signed [COORD_W-1:0] src_x;
        logic signed [COORD_W-1:0] src_y;
        logic [GLYPH_W-1:0]        glyph;
        logic                      clip_source;
        logic                      skip_spaces;
    } t_in_req;

    // output request: one buffer write
    typedef struct packed {
        logic               write_enable;
        logic [ADDR_W-1:0]  cell_address;
        logic [GLYPH_W-1:0] glyph_out;
    } t_out_req;

endpackage

>>> hw/rtl/affine_char_plot_address_top.sv
// ----------------------------------------------------------------------------
// affine_char_plot_address_top
// Maps a source point through a 16.16 fixed point 2-D affine transform,
// bounds checks it against the screen and gives the linear cell address.
// ----------------------------------------------------------------------------
// The unit takes one request per clock unless stalled and delivers its result
// through a four-stage pipeline: products, sums and floor, bounds test
// with row multiply, then the address add in the output register. The input
// side stalls only when all four stages hold requests and the output is
// stalled. Configuration registers are written through a plain write port and
// must only change while no request is in flight.
module affine_char_plot_address_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [acpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [acpa_pkg::COEF_W-1:0]         i_cfg_data,
    // input channel
    input  logic                                i_valid,
    input  acpa_pkg::t_in_req                   i_req,
    output logic                                o_stall,
    // output channel
    output logic                                o_valid,
    output acpa_pkg::t_out_req                  o_req,
    input  logic                                i_stall
);
    import acpa_pkg::*;

    // configuration registers
    logic signed [COEF_W-1:0] r_coef_xx, r_coef_xy, r_offset_x;
    logic signed [COEF_W-1:0] r_coef_yx, r_coef_yy, r_offset_y;
    logic [DIM_W-1:0]         r_screen_width, r_screen_height;

    // saturated dimensions
    logic [DIM_W-1:0] w_sat, h_sat;

    // stage enables
    logic en1, en2, en3, en4;

    // stage 1 registers
    logic                      r1_valid;
    logic signed [47:0]        r1_pxx, r1_pxy, r1_pyx, r1_pyy;
    logic signed [25:0]        r1_yw;
    logic [16:0]               r1_wh;
    logic signed [COORD_W-1:0] r1_x, r1_y;
    logic [GLYPH_W-1:0]        r1_glyph;
    logic                      r1_clip, r1_skip_hit;

    // stage 2 registers
    logic                      r2_valid;
    logic signed [33:0]        r2_px, r2_py;
    logic                      r2_keep;
    logic [GLYPH_W-1:0]        r2_glyph;

    // stage 3 registers
    logic                      r3_valid;
    logic                      r3_we;
    logic [7:0]                r3_px;
    logic [16:0]               r3_row;
    logic [GLYPH_W-1:0]        r3_glyph;

    // stage 4 (output) registers
    logic                      r4_valid;
    t_out_req                  r4_req;

    // stage 2 combinational values
    logic signed [49:0]        n_sum_x, n_sum_y;
    logic signed [16:0]        x17, y17, w17, h17;
    logic signed [26:0]        lin27, wh27;
    logic                      n_drop;

    // stage 3 combinational values
    logic signed [33:0]        w34, h34;
    logic                      n_inb;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_xx       <= COEF_ONE;
            r_coef_xy       <= COEF_ZERO;
            r_offset_x      <= COEF_ZERO;
            r_coef_yx       <= COEF_ZERO;
            r_coef_yy       <= COEF_ONE;
            r_offset_y      <= COEF_ZERO;
            r_screen_width  <= WIDTH_RESET;
            r_screen_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COEF_XX:       r_coef_xx <= i_cfg_data;
                CFG_COEF_XY:       r_coef_xy <= i_cfg_data;
                CFG_OFFSET_X:      r_offset_x <= i_cfg_data;
                CFG_COEF_YX:       r_coef_yx <= i_cfg_data;
                CFG_COEF_YY:       r_coef_yy <= i_cfg_data;
                CFG_OFFSET_Y:      r_offset_y <= i_cfg_data;
                CFG_SCREEN_WIDTH:  r_screen_width <= i_cfg_data[DIM_W-1:0];
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // dimension saturation
    assign w_sat = (r_screen_width > MAX_DIM) ? MAX_DIM : r_screen_width;
    assign h_sat = (r_screen_height > MAX_DIM) ? MAX_DIM : r_screen_height;

    // pipeline advance, a stage moves when empty or when the next one moves
    assign en4 = !r4_valid || !i_stall;
    assign en3 = !r3_valid || en4;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;
    assign o_stall = !en1;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (en1) r1_valid <= i_valid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
            if (en4) r4_valid <= r3_valid;
        end
    end

    // stage 1: transform products and source clip products
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_pxx      <= 48'(i_req.src_x * r_coef_xx);
            r1_pxy      <= 48'(i_req.src_y * r_coef_xy);
            r1_pyx      <= 48'(i_req.src_x * r_coef_yx);
            r1_pyy      <= 48'(i_req.src_y * r_coef_yy);
            r1_yw       <= 26'(i_req.src_y * $signed({1'b0, w_sat}));
            r1_wh       <= 17'(w_sat * h_sat);
            r1_x        <= i_req.src_x;
            r1_y        <= i_req.src_y;
            r1_glyph    <= i_req.glyph;
            r1_clip     <= i_req.clip_source;
            r1_skip_hit <= i_req.skip_spaces && (i_req.glyph == SPACE_CODE);
        end
    end

    // stage 2: exact sums, floor by dropping the fraction, source clip test
    assign n_sum_x = $signed({{2{r1_pxx[47]}}, r1_pxx}) + $signed({{2{r1_pxy[47]}}, r1_pxy})
                   + $signed({{18{r_offset_x[31]}}, r_offset_x});
    assign n_sum_y = $signed({{2{r1_pyx[47]}}, r1_pyx}) + $signed({{2{r1_pyy[47]}}, r1_pyy})
                   + $signed({{18{r_offset_y[31]}}, r_offset_y});
    assign x17   = $signed({r1_x[COORD_W-1], r1_x});
    assign y17   = $signed({r1_y[COORD_W-1], r1_y});
    assign w17   = $signed({8'b0, w_sat});
    assign h17   = $signed({8'b0, h_sat});
    assign lin27 = $signed({r1_yw[25], r1_yw}) + $signed({{11{r1_x[COORD_W-1]}}, r1_x});
    assign wh27  = $signed({10'b0, r1_wh});
    assign n_drop = r1_clip && ((x17 >= w17) || (y17 >= h17) || (lin27 >= wh27));

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_px    <= n_sum_x[49:FRAC_BITS];
            r2_py    <= n_sum_y[49:FRAC_BITS];
            r2_keep  <= !n_drop && !r1_skip_hit;
            r2_glyph <= r1_glyph;
        end
    end

    // stage 3: screen bounds test and row offset multiply
    assign w34   = $signed({25'b0, w_sat});
    assign h34   = $signed({25'b0, h_sat});
    assign n_inb = !r2_px[33] && !r2_py[33] && (r2_px < w34) && (r2_py < h34);

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_we    <= r2_keep && n_inb;
            r3_px    <= r2_px[7:0];
            r3_row   <= 17'(r2_py[7:0] * w_sat);
            r3_glyph <= r2_glyph;
        end
    end

    // stage 4: linear address, zero when the write is disabled
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_req.write_enable <= r3_we;
            r4_req.cell_address <= r3_we ? ADDR_W'(r3_row + {9'b0, r3_px}) : '0;
            r4_req.glyph_out    <= r3_glyph;
        end
    end

    assign o_valid = r4_valid;
    assign o_req   = r4_req;

    // input side only stalls when every stage is full and the output stalls
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r1_valid && r2_valid && r3_valid && r4_valid && i_stall))
        else $error("input stalled while the pipeline has room");

    // a request in the third stage reaches the output when it is not stalled
    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && !i_stall) |=> o_valid)
        else $error("request lost between third stage and output");

    // an accepted request occupies the first stage next cycle
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r1_valid)
        else $error("accepted request not captured");

endmodule

>>> tb/affine_char_plot_address_checker.sv
// ----------------------------------------------------------------------------
// affine_char_plot_address_checker
// Watches the configuration port and both request channels of the affine
// character plot address unit. It predicts every buffer write from its own
// copy of the transform registers, then compares each delivered request field
// by field against the oldest prediction. It reports the running mismatch
// count and how many results are still outstanding.
// ----------------------------------------------------------------------------
module affine_char_plot_address_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration port as driven into the unit
    input  logic                           i_cfg_we,
    input  logic [acpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [acpa_pkg::COEF_W-1:0]    i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    input  acpa_pkg::t_in_req              i_in_req,
    input  logic                           i_in_stall,
    // output channel
    input  logic                           i_out_valid,
    input  acpa_pkg::t_out_req             i_out_req,
    input  logic                           i_out_stall,
    // status for the testbench top
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import acpa_pkg::*;

    // shadow copy of the transform and screen registers
    logic signed [COEF_W-1:0] shadow_xx;
    logic signed [COEF_W-1:0] shadow_xy;
    logic signed [COEF_W-1:0] shadow_ox;
    logic signed [COEF_W-1:0] shadow_yx;
    logic signed [COEF_W-1:0] shadow_yy;
    logic signed [COEF_W-1:0] shadow_oy;
    logic [DIM_W-1:0]         shadow_width;
    logic [DIM_W-1:0]         shadow_height;

    // buffer writes predicted but not yet delivered, oldest first
    t_out_req plot_writes_q[$];

    // expected buffer write for one source point
    function automatic t_out_req plot_predict(input t_in_req pt);
        longint   x;
        longint   y;
        longint   w;
        longint   h;
        longint   px;
        longint   py;
        logic     keep;
        t_out_req res;
        x = longint'($signed(pt.src_x));
        y = longint'($signed(pt.src_y));
        w = (shadow_width > MAX_DIM) ? longint'(MAX_DIM) : longint'(shadow_width);
        h = (shadow_height > MAX_DIM) ? longint'(MAX_DIM) : longint'(shadow_height);
        // exact sums, floor by arithmetic shift of the fraction
        px = (x * longint'(shadow_xx) + y * longint'(shadow_xy) + longint'(shadow_ox))
             >>> FRAC_BITS;
        py = (x * longint'(shadow_yx) + y * longint'(shadow_yy) + longint'(shadow_oy))
             >>> FRAC_BITS;
        keep = 1'b1;
        // source pre-clip, negative source coordinates pass
        if (pt.clip_source && (x >= w || y >= h || y * w + x >= w * h))
            keep = 1'b0;
        if (px < 0 || py < 0 || px >= w || py >= h)
            keep = 1'b0;
        // transparent space
        if (pt.skip_spaces && pt.glyph == SPACE_CODE)
            keep = 1'b0;
        res.write_enable = keep;
        res.cell_address = keep ? ADDR_W'(py * w + px) : '0;
        res.glyph_out    = pt.glyph;
        return res;
    endfunction

    // register shadowing, prediction and comparison
    always @(posedge i_clk) begin
        t_out_req want;
        int       nerr;
        nerr = 0;
        if (!i_rst_n) begin
            shadow_xx     <= COEF_ONE;
            shadow_xy     <= COEF_ZERO;
            shadow_ox     <= COEF_ZERO;
            shadow_yx     <= COEF_ZERO;
            shadow_yy     <= COEF_ONE;
            shadow_oy     <= COEF_ZERO;
            shadow_width  <= WIDTH_RESET;
            shadow_height <= HEIGHT_RESET;
            plot_writes_q.delete();
            o_fail_count  <= 0;
            o_pending     <= 0;
        end else begin
            // delivered request against oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (plot_writes_q.size() == 0) begin
                    $display("%0t: result with nothing outstanding, expected none actual %p",
                             $time, i_out_req);
                    nerr++;
                end else begin
                    want = plot_writes_q.pop_front();
                    if (i_out_req.write_enable !== want.write_enable) begin
                        $display("%0t: write_enable expected %0b actual %0b",
                                 $time, want.write_enable, i_out_req.write_enable);
                        nerr++;
                    end
                    if (i_out_req.cell_address !== want.cell_address) begin
                        $display("%0t: cell_address expected %h actual %h",
                                 $time, want.cell_address, i_out_req.cell_address);
                        nerr++;
                    end
                    if (i_out_req.glyph_out !== want.glyph_out) begin
                        $display("%0t: glyph_out expected %h actual %h",
                                 $time, want.glyph_out, i_out_req.glyph_out);
                        nerr++;
                    end
                end
            end
            // accepted request, appended at the tail
            if (i_in_valid && !i_in_stall)
                plot_writes_q.insert(plot_writes_q.size(), plot_predict(i_in_req));
            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_COEF_XX:       shadow_xx     <= i_cfg_data;
                    CFG_COEF_XY:       shadow_xy     <= i_cfg_data;
                    CFG_OFFSET_X:      shadow_ox     <= i_cfg_data;
                    CFG_COEF_YX:       shadow_yx     <= i_cfg_data;
                    CFG_COEF_YY:       shadow_yy     <= i_cfg_data;
                    CFG_OFFSET_Y:      shadow_oy     <= i_cfg_data;
                    CFG_SCREEN_WIDTH:  shadow_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_SCREEN_HEIGHT: shadow_height <= i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            o_fail_count <= o_fail_count + nerr;
            o_pending    <= plot_writes_q.size();
        end
    end

endmodule

>>> tb/tb_affine_char_plot_address_top.sv
// ----------------------------------------------------------------------------
// tb_affine_char_plot_address_top
// Drives the affine character plot address unit with a directed set of
// extreme points and clip and space cases, then with random points over a
// series of register settings, with random gaps and output stalls. A checker
// beside the unit predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_affine_char_plot_address_top;
    timeunit 1ns;
    timeprecision 1ps;
    import acpa_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int TAIL_CYCLES   = 12;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_POINTS  = 120;

    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    t_cfg_idx       cfg_index;
    logic [31:0]    cfg_data;
    logic           in_valid;
    t_in_req        in_req;
    logic           dut_stall;
    logic           dut_valid;
    t_out_req       dut_req;
    logic           out_stall = 1'b0;
    int             fail_count;
    int             chk_pending;
    int             idle_cycles;
    logic           in_burst  = 1'b0;
    logic           out_burst = 1'b0;
    logic [31:0]    set_val [8];

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    affine_char_plot_address_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_valid     (in_valid),
        .i_req       (in_req),
        .o_stall     (dut_stall),
        .o_valid     (dut_valid),
        .o_req       (dut_req),
        .i_stall     (out_stall)
    );

    affine_char_plot_address_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_req     (in_req),
        .i_in_stall   (dut_stall),
        .i_out_valid  (dut_valid),
        .i_out_req    (dut_req),
        .i_out_stall  (out_stall),
        .o_fail_count (fail_count),
        .o_pending    (chk_pending)
    );

    // watchdog on cycles without any accepted request, delivered result or register write
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((in_valid && !dut_stall) || (dut_valid && !out_stall) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL affine_char_plot_address_top");
                $finish;
            end
        end
    end

    // output side: random stall before each result, with stall-free stretches
    initial begin
        int hold;
        forever begin
            if ($urandom_range(0, 39) == 0)
                out_burst = !out_burst;
            hold = out_burst ? 0 : $urandom_range(0, 16);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(dut_valid && !out_stall));
        end
    end

    // random signed 16.16 coefficient in [-span, span]
    function automatic logic [31:0] rand_coef(input int span);
        return 32'($urandom_range(0, 2 * span) - span);
    endfunction

    // screen dimension, mostly in range, sometimes zero or saturating, junk above
    function automatic logic [31:0] rand_dim();
        int          pick;
        logic [31:0] d;
        pick = $urandom_range(0, 19);
        d = $urandom() & 32'hFFFF_FE00;
        if (pick == 1)
            d |= $urandom_range(257, 511);
        else if (pick != 0)
            d |= $urandom_range(1, 256);
        return d;
    endfunction

    // hold the sender off until every predicted write has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (chk_pending != 0);
    endtask

    // write all eight registers from set_val while the unit is empty
    task automatic write_regs();
        t_cfg_idx k;
        wait_idle();
        k = k.first();
        repeat (8) begin
            cfg_we    <= 1'b1;
            cfg_index <= k;
            cfg_data  <= set_val[k];
            @(posedge clk);
            k = k.next();
        end
        cfg_we <= 1'b0;
    endtask

    task automatic load_regs(input logic [31:0] xx, xy, ox, yx, yy, oy, w, h);
        set_val[CFG_COEF_XX]       = xx;
        set_val[CFG_COEF_XY]       = xy;
        set_val[CFG_OFFSET_X]      = ox;
        set_val[CFG_COEF_YX]       = yx;
        set_val[CFG_COEF_YY]       = yy;
        set_val[CFG_OFFSET_Y]      = oy;
        set_val[CFG_SCREEN_WIDTH]  = w;
        set_val[CFG_SCREEN_HEIGHT] = h;
        write_regs();
    endtask

    // one plot request after a random gap, held until accepted
    task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                              input logic [7:0] g, input logic clip, input logic skip);
        t_in_req pt;
        int      gap;
        pt.src_x       = x;
        pt.src_y       = y;
        pt.glyph       = g;
        pt.clip_source = clip;
        pt.skip_spaces = skip;
        if ($urandom_range(0, 39) == 0)
            in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= pt;
        do @(posedge clk); while (!(in_valid && !dut_stall));
    endtask

    // stimulus and verdict
    initial begin
        int          kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  g;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_COEF_XX;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_req    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: identity on an 80 by 25 screen
        send_point(16'd0, 16'd0, 8'h41, 1'b0, 1'b0);
        send_point(16'd79, 16'd24, 8'h42, 1'b0, 1'b0);
        send_point(16'd80, 16'd0, 8'h43, 1'b0, 1'b0);
        send_point(16'd0, 16'd25, 8'h44, 1'b0, 1'b0);
        send_point(16'hFFFF, 16'd0, 8'h45, 1'b0, 1'b1);
        send_point(16'd0, 16'hFFFF, 8'h46, 1'b1, 1'b0);
        send_point(16'h7FFF, 16'h7FFF, 8'hFF, 1'b0, 1'b0);
        send_point(16'h8000, 16'h8000, 8'h00, 1'b0, 1'b0);
        send_point(16'd5, 16'd5, SPACE_CODE, 1'b0, 1'b1);
        send_point(16'd5, 16'd5, SPACE_CODE, 1'b0, 1'b0);
        send_point(16'd79, 16'd24, 8'h47, 1'b1, 1'b1);

        // mirrored x with half-cell offset: source clip and negative source
        load_regs(32'hFFFF_0000, COEF_ZERO, 32'h0064_8000, COEF_ZERO, COEF_ONE,
                  32'h000A_0000, 32'd80, 32'd25);
        send_point(16'd85, 16'd2, 8'h48, 1'b1, 1'b0);
        send_point(16'd85, 16'd2, 8'h49, 1'b0, 1'b0);
        send_point(16'd30, 16'hFFFB, 8'h4A, 1'b1, 1'b0);
        send_point(16'd100, 16'd0, 8'h4B, 1'b0, 1'b0);
        send_point(16'd101, 16'd0, 8'h4C, 1'b0, 1'b0);

        // extreme coefficients, saturated width, zero height
        load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FE00);
        send_point(16'h7FFF, 16'h8000, 8'h55, 1'b0, 1'b0);
        send_point(16'h8000, 16'h7FFF, 8'hAA, 1'b1, 1'b1);
        send_point(16'h7FFF, 16'h7FFF, 8'h01, 1'b0, 1'b0);
        send_point(16'h8000, 16'h8000, 8'hFE, 1'b0, 1'b0);

        // largest screen, last cell at the top of the address range
        load_regs(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO,
                  32'h0000_01FF, 32'h0000_0100);
        send_point(16'd255, 16'd255, 8'h5A, 1'b1, 1'b0);
        send_point(16'd256, 16'd0, 8'h5B, 1'b0, 1'b0);
        send_point(16'd0, 16'd256, 8'h5C, 1'b1, 1'b0);

        // single cell screen
        load_regs(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO,
                  32'd1, 32'd1);
        send_point(16'd0, 16'd0, SPACE_CODE, 1'b1, 1'b1);
        send_point(16'd0, 16'd0, 8'h78, 1'b1, 1'b1);

        // random settings, each followed by random points
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            kind = p % 4;
            case (kind)
                0: begin
                    set_val[CFG_COEF_XX] = rand_coef(2 << 16);
                    set_val[CFG_COEF_YY] = rand_coef(2 << 16);
                    set_val[CFG_COEF_XY] = $urandom_range(0, 1) ? rand_coef(1 << 15) : COEF_ZERO;
                    set_val[CFG_COEF_YX] = $urandom_range(0, 1) ? rand_coef(1 << 15) : COEF_ZERO;
                end
                1: begin
                    set_val[CFG_COEF_XX] = rand_coef(1 << 16);
                    set_val[CFG_COEF_XY] = rand_coef(1 << 16);
                    set_val[CFG_COEF_YX] = rand_coef(1 << 16);
                    set_val[CFG_COEF_YY] = rand_coef(1 << 16);
                end
                2: begin
                    set_val[CFG_COEF_XX] = COEF_ONE + rand_coef(1 << 12);
                    set_val[CFG_COEF_XY] = rand_coef(1 << 10);
                    set_val[CFG_COEF_YX] = rand_coef(1 << 10);
                    set_val[CFG_COEF_YY] = COEF_ONE + rand_coef(1 << 12);
                end
                default: begin
                    set_val[CFG_COEF_XX] = $urandom();
                    set_val[CFG_COEF_XY] = $urandom();
                    set_val[CFG_COEF_YX] = $urandom();
                    set_val[CFG_COEF_YY] = $urandom();
                end
            endcase
            // offsets near the screen, except for the wild settings
            if (kind == 3) begin
                set_val[CFG_OFFSET_X] = $urandom();
                set_val[CFG_OFFSET_Y] = $urandom();
            end else begin
                set_val[CFG_OFFSET_X] = 32'($urandom_range(0, 280 << 16) - (20 << 16));
                set_val[CFG_OFFSET_Y] = 32'($urandom_range(0, 280 << 16) - (20 << 16));
            end
            set_val[CFG_SCREEN_WIDTH]  = rand_dim();
            set_val[CFG_SCREEN_HEIGHT] = rand_dim();
            write_regs();

            repeat (PHASE_POINTS) begin
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
                // mostly points around the screen, some anywhere
                if ($urandom_range(0, 4) == 0) begin
                    x = $urandom();
                    y = $urandom();
                end else begin
                    x = 16'($urandom_range(0, 300) - 20);
                    y = 16'($urandom_range(0, 300) - 20);
                end
                g = ($urandom_range(0, 3) == 0) ? SPACE_CODE : 8'($urandom_range(0, 255));
                send_point(x, y, g, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end

        // drain, then let the pipeline settle before the verdict
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS affine_char_plot_address_top");
        else
            $display("FAIL affine_char_plot_address_top");
        $finish;
    end

endmodule
